// ===== src/dsched_pkg.sv =====
// ----------------------------------------------------------------------------
// dsched_pkg
// shared types, widths, mode codes and controller interface for the disk
// request scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package dsched_pkg;

   localparam int MAX_REQUESTS = 64;
   localparam int CYLINDERS    = 7400;
   localparam int POS_W        = 13;
   localparam int IDX_W        = $clog2(MAX_REQUESTS);
   localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);

   localparam logic [2:0] MODE_LOAD   = 3'd0;
   localparam logic [2:0] MODE_CLEAR  = 3'd1;
   localparam logic [2:0] MODE_NEAR   = 3'd2;
   localparam logic [2:0] MODE_SWEEP  = 3'd3;
   localparam logic [2:0] MODE_AHEAD  = 3'd4;
   localparam logic [2:0] MODE_MARK   = 3'd5;

   typedef struct packed {
      logic [2:0]       mode;
      logic [POS_W-1:0] position;
      logic             direction;
      logic             take;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] entry_index;
      logic [POS_W-1:0] distance;
      logic [CNT_W-1:0] served_count;
      logic [POS_W-1:0] last_pos;
      logic             all_done;
      logic             status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic do_load;
      logic do_clear;
      logic i_clear;
      logic i_inc;
      logic j_clear;
      logic j_inc;
      logic rd_j;
      logic eval;
      logic latch_cur;
      logic serve;
      logic finish;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       empty;
      logic       last_i;
      logic       i_zero;
      logic       last_j;
      logic       cand;
      logic       hit;
      logic       dup;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/disk_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// disk_request_scheduler
// sstf and scan service over a table of up to 64 cylinder requests
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// the single response word has been shown on rsp_data for one cycle with
// rsp_valid high, and the receiver cannot stall it. Load, clear and unused
// modes go straight from dispatch to the response. Nearest, ahead and mark
// read the table one entry at a time through the single memory read port,
// each entry being read and then evaluated; ahead and mark stop at the first
// hit. A sweep also searches the earlier entries for each in-range candidate.
// There is no clearing pass after reset.
`default_nettype none

module disk_request_scheduler #(
   parameter int CYLINDERS = dsched_pkg::CYLINDERS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire dsched_pkg::req_type req_data,
   output logic                     rsp_valid,
   output dsched_pkg::rsp_type      rsp_data
);

   dsched_pkg::cmd_type  cmd;
   dsched_pkg::stat_type stat;

   dsched_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   dsched_dp #(
      .CYLINDERS (CYLINDERS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_data)
   );

   assign rsp_valid = cmd.respond;

endmodule

`default_nettype wire

// ===== src/dsched_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsched_ctrl
// sequencer that walks the request table one entry at a time and, for a
// sweep, searches earlier entries for a same-cylinder entry served this pass
// ----------------------------------------------------------------------------
`default_nettype none

module dsched_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire dsched_pkg::stat_type stat,
   output dsched_pkg::cmd_type       cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_EVAL  = 4'd3;
   localparam logic [3:0] S_SERVE = 4'd4;
   localparam logic [3:0] S_JRD   = 4'd5;
   localparam logic [3:0] S_JEV   = 4'd6;
   localparam logic [3:0] S_FIN   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [3:0] adv_state;
   logic       adv_inc;

   always_comb begin
      adv_state = stat.last_i ? S_FIN : S_RD;
      adv_inc   = !stat.last_i;
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.op) inside
               dsched_pkg::MODE_LOAD: begin
                  cmd.do_load = 1'b1;
                  state_in    = S_RESP;
               end
               dsched_pkg::MODE_CLEAR: begin
                  cmd.do_clear = 1'b1;
                  state_in     = S_RESP;
               end
               dsched_pkg::MODE_NEAR, dsched_pkg::MODE_SWEEP,
               dsched_pkg::MODE_AHEAD, dsched_pkg::MODE_MARK: begin
                  cmd.i_clear = 1'b1;
                  state_in    = stat.empty ? S_RESP : S_RD;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_RD: state_in = S_EVAL;
         S_EVAL: begin
            cmd.eval = 1'b1;
            if ((stat.op == dsched_pkg::MODE_AHEAD || stat.op == dsched_pkg::MODE_MARK)
                && stat.hit) begin
               state_in = S_FIN;
            end else if (stat.op == dsched_pkg::MODE_SWEEP && stat.cand) begin
               cmd.latch_cur = 1'b1;
               if (stat.i_zero) begin
                  state_in = S_SERVE;
               end else begin
                  cmd.j_clear = 1'b1;
                  state_in    = S_JRD;
               end
            end else begin
               cmd.i_inc = adv_inc;
               state_in  = adv_state;
            end
         end
         S_SERVE: begin
            cmd.serve = 1'b1;
            cmd.i_inc = adv_inc;
            state_in  = adv_state;
         end
         S_JRD: begin
            cmd.rd_j = 1'b1;
            state_in = S_JEV;
         end
         S_JEV: begin
            if (stat.dup) begin
               cmd.i_inc = adv_inc;
               state_in  = adv_state;
            end else if (stat.last_j) begin
               state_in = S_SERVE;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_JRD;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("block still busy after its response");
   a_serve_from: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SERVE) |-> ($past(state_ff) == S_EVAL || $past(state_ff) == S_JEV))
      else $error("serve step entered from an unexpected state");
`endif

endmodule

`default_nettype wire

// ===== src/dsched_dp.sv =====
// ----------------------------------------------------------------------------
// dsched_dp
// request table, served flags, one-read-port cylinder memory and the
// per-entry compare and update logic
// ----------------------------------------------------------------------------
`default_nettype none

module dsched_dp #(
   parameter int CYLINDERS = dsched_pkg::CYLINDERS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire dsched_pkg::req_type req,
   input  wire dsched_pkg::cmd_type cmd,
   output dsched_pkg::stat_type     stat,
   output dsched_pkg::rsp_type      rsp
);

   localparam int MAXR  = dsched_pkg::MAX_REQUESTS;
   localparam int IDX_W = dsched_pkg::IDX_W;
   localparam int CNT_W = dsched_pkg::CNT_W;
   localparam int POS_W = dsched_pkg::POS_W;

   logic [POS_W-1:0] cyl_mem [MAXR];
   logic [POS_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   logic [2:0]       mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             dir_ff, dir_in;
   logic             take_ff, take_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [MAXR-1:0]  served_ff, served_in;
   logic [MAXR-1:0]  now_ff, now_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [POS_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] last_ff, last_in;
   logic             hit_ff, hit_in;
   logic             full_ff, full_in;

   logic [POS_W-1:0] gap;
   logic             full_now;
   logic [MAXR-1:0]  valid;
   logic             below_end;

   assign rd_addr = cmd.rd_j ? j_ff : i_ff;
   assign full_now = (count_ff >= CNT_W'(MAXR));

   always_ff @(posedge clock) begin
      if (cmd.do_load && !full_now) begin
         cyl_mem[count_ff[IDX_W-1:0]] <= pos_ff;
      end
      rd_data_ff <= cyl_mem[rd_addr];
   end

   always_comb begin
      gap       = (rd_data_ff > pos_ff) ? (rd_data_ff - pos_ff) : (pos_ff - rd_data_ff);
      below_end = (32'(rd_data_ff) < 32'(CYLINDERS));
      for (int k = 0; k < MAXR; k++) begin
         valid[k] = (CNT_W'(k) < count_ff);
      end
   end

   always_comb begin
      stat.op     = mode_ff;
      stat.empty  = (count_ff == '0);
      stat.last_i = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);
      stat.i_zero = (i_ff == '0);
      stat.last_j = ((j_ff + IDX_W'(1)) == i_ff);
      stat.cand   = !served_ff[i_ff] &&
                    (dir_ff ? (rd_data_ff <= pos_ff) : (rd_data_ff >= pos_ff && below_end));
      stat.dup    = now_ff[j_ff] && (rd_data_ff == cur_ff);
      if (mode_ff == dsched_pkg::MODE_MARK) begin
         stat.hit = (rd_data_ff == pos_ff);
      end else begin
         stat.hit = !served_ff[i_ff] &&
                    (dir_ff ? (rd_data_ff < pos_ff) : (rd_data_ff > pos_ff));
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      dir_in      = dir_ff;
      take_in     = take_ff;
      count_in    = count_ff;
      served_in   = served_ff;
      now_in      = now_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      found_in    = found_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      hit_in      = hit_ff;
      full_in     = full_ff;

      if (cmd.capture) begin
         mode_in     = req.mode;
         pos_in      = req.position;
         dir_in      = req.direction;
         take_in     = req.take;
         now_in      = '0;
         best_in     = '0;
         best_idx_in = '0;
         found_in    = 1'b0;
         cnt_in      = '0;
         last_in     = req.position;
         hit_in      = 1'b0;
         full_in     = 1'b0;
      end
      if (cmd.do_load) begin
         if (full_now) begin
            full_in = 1'b1;
         end else begin
            served_in[count_ff[IDX_W-1:0]] = 1'b0;
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.do_clear) begin
         count_in  = '0;
         served_in = '0;
      end
      if (cmd.i_clear) i_in = '0;
      if (cmd.i_inc)   i_in = i_ff + IDX_W'(1);
      if (cmd.j_clear) j_in = '0;
      if (cmd.j_inc)   j_in = j_ff + IDX_W'(1);
      if (cmd.latch_cur) cur_in = rd_data_ff;
      if (cmd.eval) begin
         case (mode_ff)
            dsched_pkg::MODE_NEAR: begin
               if (!served_ff[i_ff] && (!found_ff || gap < best_ff)) begin
                  found_in    = 1'b1;
                  best_in     = gap;
                  best_idx_in = i_ff;
               end
            end
            dsched_pkg::MODE_AHEAD: begin
               if (stat.hit) found_in = 1'b1;
            end
            dsched_pkg::MODE_MARK: begin
               if (stat.hit) begin
                  found_in          = 1'b1;
                  served_in[i_ff]   = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (cmd.serve) begin
         now_in[i_ff] = 1'b1;
         cnt_in       = cnt_ff + CNT_W'(1);
         hit_in       = 1'b1;
         if (!hit_ff || (dir_ff ? (cur_ff < last_ff) : (cur_ff > last_ff))) begin
            last_in = cur_ff;
         end
      end
      if (cmd.finish) begin
         if (mode_ff == dsched_pkg::MODE_NEAR && take_ff && found_ff) begin
            served_in[best_idx_ff] = 1'b1;
         end
         if (mode_ff == dsched_pkg::MODE_SWEEP) begin
            served_in = served_ff | now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         served_ff <= '0;
      end else begin
         count_ff  <= count_in;
         served_ff <= served_in;
      end
      mode_ff     <= mode_in;
      pos_ff      <= pos_in;
      dir_ff      <= dir_in;
      take_ff     <= take_in;
      now_ff      <= now_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      found_ff    <= found_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      hit_ff      <= hit_in;
      full_ff     <= full_in;
   end

   always_comb begin
      rsp              = '0;
      rsp.all_done     = ~|(valid & ~served_ff);
      rsp.found        = found_ff && (mode_ff == dsched_pkg::MODE_NEAR ||
                                      mode_ff == dsched_pkg::MODE_AHEAD ||
                                      mode_ff == dsched_pkg::MODE_MARK);
      if (mode_ff == dsched_pkg::MODE_NEAR && found_ff) begin
         rsp.entry_index = best_idx_ff;
         rsp.distance    = best_ff;
      end
      if (mode_ff == dsched_pkg::MODE_SWEEP) begin
         rsp.served_count = cnt_ff;
         rsp.last_pos     = last_ff;
      end
      rsp.status = (mode_ff == dsched_pkg::MODE_LOAD) && full_ff;
   end

`ifndef SYNTH
   a_eval_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> (CNT_W'(i_ff) < count_ff))
      else $error("table entry read beyond the fill count");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAXR))
      else $error("fill count above table depth");
   a_serve_once: assert property (@(posedge clock) disable iff (reset)
      cmd.serve |-> !now_ff[i_ff])
      else $error("entry served twice in one sweep");
`endif

endmodule

`default_nettype wire
